// ===== rtl/wtdc_pkg.sv =====
`default_nettype none

package wtdc_pkg;

   // Request codes
   localparam logic [2:0] REQ_TICK       = 3'd0;
   localparam logic [2:0] REQ_PORT_A     = 3'd1;
   localparam logic [2:0] REQ_PORT_B     = 3'd2;
   localparam logic [2:0] REQ_DIVIDE_SET = 3'd3;
   localparam logic [2:0] REQ_ENABLE_SET = 3'd4;

   localparam int          ADDR_W   = 9;
   localparam logic [3:0]  RATE_TOP = 4'd15;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] data;
      logic       line_level;
   } wtdc_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prom_address;
      logic              fetch;
      logic [3:0]        volume;
      logic              volume_changed;
   } wtdc_rsp_type;

   // Handshake between the pipeline stages
   typedef struct packed {
      logic valid;
      logic advance;
   } wtdc_stage_type;

endpackage

`default_nettype wire

// ===== rtl/wtdc_in_reg.sv =====
`default_nettype none

module wtdc_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire wtdc_pkg::wtdc_req_type req_payload,
   input  wire logic                  advance,
   output wtdc_pkg::wtdc_stage_type   stage,
   output wtdc_pkg::wtdc_req_type     item
);

   logic                  valid_ff, valid_in;
   wtdc_pkg::wtdc_req_type item_ff, item_in;
   logic                  take;

   // Accept a transfer when empty or when the held item moves on
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b1;
         item_in  = req_payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.advance = advance;
   assign item          = item_ff;

endmodule

`default_nettype wire

// ===== rtl/wtdc_chain.sv =====
`default_nettype none

module wtdc_chain #(
   parameter int STEP_BITS = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wtdc_pkg::wtdc_stage_type stage,
   input  wire wtdc_pkg::wtdc_req_type  item,
   output wtdc_pkg::wtdc_rsp_type      result
);

   localparam int FULL_W = 4 + STEP_BITS;

   logic [1:0]           prescaler_ff, prescaler_in;
   logic                 divided_ff, divided_in;
   logic [3:0]           rate_ff, rate_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [3:0]           wave_ff, wave_in;
   logic [3:0]           preset_ff, preset_in;
   logic [3:0]           volume_ff, volume_in;
   logic                 divide_line_ff, divide_line_in;
   logic                 enable_line_ff, enable_line_in;

   logic                 sel;
   logic                 fetch;
   logic                 vchg;
   logic                 fire;
   logic [FULL_W-1:0]    full_addr;
   logic [FULL_W+wtdc_pkg::ADDR_W-1:0] wide_addr;

   assign fire = stage.valid && stage.advance;

   // Next state of the divider chain and port registers
   always_comb begin
      prescaler_in   = prescaler_ff;
      divided_in     = divided_ff;
      rate_in        = rate_ff;
      step_in        = step_ff;
      wave_in        = wave_ff;
      preset_in      = preset_ff;
      volume_in      = volume_ff;
      divide_line_in = divide_line_ff;
      enable_line_in = enable_line_ff;
      fetch          = 1'b0;
      vchg           = 1'b0;
      sel            = 1'b0;
      case (item.req_type)
         wtdc_pkg::REQ_TICK: begin
            prescaler_in = prescaler_ff + 2'd1;
            sel = divide_line_ff ? prescaler_in[0] : prescaler_in[1];
            if (sel != divided_ff) begin
               divided_in = sel;
               if (rate_ff != wtdc_pkg::RATE_TOP) begin
                  rate_in = rate_ff + 4'd1;
               end else begin
                  rate_in = preset_ff;
                  if (!enable_line_ff) begin
                     step_in = step_ff + {{(STEP_BITS-1){1'b0}}, 1'b1};
                     fetch   = 1'b1;
                  end else begin
                     step_in = '0;
                  end
               end
            end
         end
         wtdc_pkg::REQ_PORT_A: begin
            wave_in = item.data[7:4];
            fetch   = 1'b1;
         end
         wtdc_pkg::REQ_PORT_B: begin
            preset_in = item.data[3:0];
            if (item.data[7:4] != volume_ff) begin
               volume_in = item.data[7:4];
               vchg      = 1'b1;
            end
         end
         wtdc_pkg::REQ_DIVIDE_SET: begin
            divide_line_in = item.line_level;
         end
         wtdc_pkg::REQ_ENABLE_SET: begin
            enable_line_in = item.line_level;
         end
         default: begin
         end
      endcase
   end

   // Combine wave select and step count, keep the low address bits
   assign full_addr = {wave_in, step_in};
   assign wide_addr = {{wtdc_pkg::ADDR_W{1'b0}}, full_addr};

   assign result.prom_address   = wide_addr[wtdc_pkg::ADDR_W-1:0];
   assign result.fetch          = fetch;
   assign result.volume         = volume_in;
   assign result.volume_changed = vchg;

   // Commit state only when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         prescaler_ff   <= '0;
         divided_ff     <= 1'b0;
         rate_ff        <= '0;
         step_ff        <= '0;
         wave_ff        <= '0;
         preset_ff      <= '0;
         volume_ff      <= '0;
         divide_line_ff <= 1'b0;
         enable_line_ff <= 1'b0;
      end else if (fire) begin
         prescaler_ff   <= prescaler_in;
         divided_ff     <= divided_in;
         rate_ff        <= rate_in;
         step_ff        <= step_in;
         wave_ff        <= wave_in;
         preset_ff      <= preset_in;
         volume_ff      <= volume_in;
         divide_line_ff <= divide_line_in;
         enable_line_ff <= enable_line_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/wtdc_out_reg.sv =====
`default_nettype none

module wtdc_out_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire wtdc_pkg::wtdc_rsp_type result,
   output logic                       advance,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output wtdc_pkg::wtdc_rsp_type     rsp_payload
);

   logic                  valid_ff, valid_in;
   wtdc_pkg::wtdc_rsp_type rsp_ff, rsp_in;

   // Advance when the result register is empty or being drained
   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (advance) begin
         valid_in = in_valid;
         rsp_in   = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/wavetable_tone_divider_chain.sv =====
// A request goes into the input register, and its response out of the result register.
// Throughput: one request per cycle while responses drain; while a response waits,
// one more request is held. The tick update is combinational between the two registers.
// Reset (synchronous, active high) empties both registers and clears all counters,
// the wave select, preset, volume and both control lines to zero.
`default_nettype none

module wavetable_tone_divider_chain #(
   parameter int STEP_BITS = 5
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire wtdc_pkg::wtdc_req_type  req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output wtdc_pkg::wtdc_rsp_type      rsp_payload
);

   wtdc_pkg::wtdc_stage_type stage;
   wtdc_pkg::wtdc_req_type   item;
   wtdc_pkg::wtdc_rsp_type   result;
   logic                     advance;

   wtdc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .advance     (advance),
      .stage       (stage),
      .item        (item)
   );

   wtdc_chain #(
      .STEP_BITS (STEP_BITS)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .stage  (stage),
      .item   (item),
      .result (result)
   );

   wtdc_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (stage.valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/wtdc_checker.sv =====
`default_nettype none

module wtdc_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire wtdc_pkg::wtdc_rsp_type  rsp_payload
);

   logic [3:0] last_volume_ff, last_volume_in;
   logic       rsp_xfer;

   assign rsp_xfer = rsp_valid && rsp_ready;

   // Track the volume of the last response transfer
   always_comb begin
      last_volume_in = last_volume_ff;
      if (rsp_xfer) begin
         last_volume_in = rsp_payload.volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_volume_ff <= '0;
      end else begin
         last_volume_ff <= last_volume_in;
      end
   end

   // Hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response dropped or changed");

   // Volume moves only together with the changed flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && rsp_payload.volume_changed |-> rsp_payload.volume != last_volume_ff)
      else $error("volume flagged changed but equal to previous");

   assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_payload.volume_changed |-> rsp_payload.volume == last_volume_ff)
      else $error("volume changed without flag");

   // A volume change (port B write) never comes with a fetch
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.fetch && rsp_payload.volume_changed))
      else $error("fetch and volume change in one response");

   // With the result side empty the block takes requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind wavetable_tone_divider_chain wtdc_checker u_wtdc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== dv/wavetable_tone_divider_chain_test.sv =====
`timescale 1ns / 1ps

module wavetable_tone_divider_chain_test;

   localparam int STEP_BITS = 5;

   // Request codes the block does not decode
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam logic [2:0] REQ_CODE_MAX  = 3'd7;

   // Receiver stall patterns
   localparam logic [1:0] STALL_NONE   = 2'd0;
   localparam logic [1:0] STALL_COIN   = 2'd1;
   localparam logic [1:0] STALL_HEAVY  = 2'd2;

   localparam int RANDOM_ITEMS  = 1150;
   localparam int HOLDOFF_LEN   = 300;
   localparam int DRAIN_LIMIT   = 2000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   wtdc_pkg::wtdc_req_type req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   wtdc_pkg::wtdc_rsp_type rsp_payload;

   wtdc_pkg::wtdc_req_type pending_reqs[$];
   wtdc_pkg::wtdc_rsp_type expected_tones[$];
   int           accepted_count = 0;
   int           error_count = 0;
   int           request_total = 0;

   // Shadow of the divider chain state
   logic [1:0]           prescaler_q = '0;
   logic                 divided_level_q = 1'b0;
   logic [3:0]           rate_count_q = '0;
   logic [STEP_BITS-1:0] step_count_q = '0;
   logic [3:0]           wave_select_q = '0;
   logic [3:0]           preset_q = '0;
   logic [3:0]           volume_q = '0;
   logic                 divide_line_q = 1'b0;
   logic                 enable_line_q = 1'b0;

   // Sender burst control
   int burst_left = 0;
   int gap_left = 0;

   // Receiver stall control
   int         cycle_count = 0;
   int         holdoff_left = 0;
   int         phase_left = 0;
   logic [1:0] stall_mode = STALL_NONE;

   wavetable_tone_divider_chain #(
      .STEP_BITS(STEP_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the shadow chain by one request and return the tone it produces
   function automatic wtdc_pkg::wtdc_rsp_type predict_tone(input wtdc_pkg::wtdc_req_type req);
      wtdc_pkg::wtdc_rsp_type tone;
      logic                   tap;
      logic [31:0]            full_addr;
      tone = '0;
      case (req.req_type)
         wtdc_pkg::REQ_TICK: begin
            prescaler_q = prescaler_q + 2'd1;
            tap = divide_line_q ? prescaler_q[0] : prescaler_q[1];
            if (tap != divided_level_q) begin
               divided_level_q = tap;
               if (rate_count_q != wtdc_pkg::RATE_TOP) begin
                  rate_count_q = rate_count_q + 4'd1;
               end else begin
                  // carry: reload, then step or clear the address counter
                  rate_count_q = preset_q;
                  if (!enable_line_q) begin
                     step_count_q = step_count_q + STEP_BITS'(1);
                     tone.fetch = 1'b1;
                  end else begin
                     step_count_q = '0;
                  end
               end
            end
         end
         wtdc_pkg::REQ_PORT_A: begin
            wave_select_q = req.data[7:4];
            tone.fetch = 1'b1;
         end
         wtdc_pkg::REQ_PORT_B: begin
            preset_q = req.data[3:0];
            if (req.data[7:4] != volume_q) begin
               volume_q = req.data[7:4];
               tone.volume_changed = 1'b1;
            end
         end
         wtdc_pkg::REQ_DIVIDE_SET: divide_line_q = req.line_level;
         wtdc_pkg::REQ_ENABLE_SET: enable_line_q = req.line_level;
         default: ;
      endcase
      full_addr = (32'(wave_select_q) << STEP_BITS) | 32'(step_count_q);
      tone.prom_address = full_addr[wtdc_pkg::ADDR_W-1:0];
      tone.volume = volume_q;
      return tone;
   endfunction

   task automatic queue_req(input logic [2:0] kind, input logic [7:0] data,
                            input logic level);
      wtdc_pkg::wtdc_req_type req;
      req.req_type = kind;
      req.data = data;
      req.line_level = level;
      pending_reqs.push_back(req);
   endtask

   // Drive requests in bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0 || pending_reqs.size() == 0) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_payload <= pending_reqs.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end
      end
   end

   // Stall the response side: random patterns plus two long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            rsp_ready <= 1'b0;
         end else if (cycle_count == 600 || cycle_count == 2500) begin
            holdoff_left <= HOLDOFF_LEN;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_left <= $urandom_range(8, 64);
               stall_mode <= 2'($urandom_range(STALL_NONE, STALL_HEAVY));
            end else begin
               phase_left <= phase_left - 1;
            end
            case (stall_mode)
               STALL_NONE:  rsp_ready <= 1'b1;
               STALL_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
               default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Predict on each request transfer, check on each response transfer
   always @(posedge clock) begin : tone_monitor
      wtdc_pkg::wtdc_rsp_type want;
      if (reset) begin
         prescaler_q = '0;
         divided_level_q = 1'b0;
         rate_count_q = '0;
         step_count_q = '0;
         wave_select_q = '0;
         preset_q = '0;
         volume_q = '0;
         divide_line_q = 1'b0;
         enable_line_q = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_tones.push_back(predict_tone(req_payload));
            accepted_count = accepted_count + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_tones.size() == 0) begin
               $error("response transfer with nothing expected: %h", rsp_payload);
               error_count = error_count + 1;
            end else begin
               want = expected_tones.pop_front();
               if (rsp_payload.prom_address !== want.prom_address) begin
                  $error("prom_address expected %0d actual %0d",
                         want.prom_address, rsp_payload.prom_address);
                  error_count = error_count + 1;
               end
               if (rsp_payload.fetch !== want.fetch) begin
                  $error("fetch expected %0d actual %0d", want.fetch, rsp_payload.fetch);
                  error_count = error_count + 1;
               end
               if (rsp_payload.volume !== want.volume) begin
                  $error("volume expected %0d actual %0d", want.volume, rsp_payload.volume);
                  error_count = error_count + 1;
               end
               if (rsp_payload.volume_changed !== want.volume_changed) begin
                  $error("volume_changed expected %0d actual %0d",
                         want.volume_changed, rsp_payload.volume_changed);
                  error_count = error_count + 1;
               end
            end
         end
      end
   end

   // Build the stimulus, release reset, wait for the drain
   initial begin
      int         n;
      int         drain;
      logic [3:0] last_vol;
      logic [3:0] vol;
      logic [3:0] preset;

      // directed: unknown codes, port extremes, line changes, ignored fields
      queue_req(wtdc_pkg::REQ_TICK, 8'hff, 1'b1);
      queue_req(REQ_UNUSED_LO, 8'h00, 1'b0);
      queue_req(REQ_CODE_MAX, 8'hff, 1'b1);
      queue_req(wtdc_pkg::REQ_PORT_B, 8'hff, 1'b1);
      queue_req(wtdc_pkg::REQ_PORT_B, 8'hff, 1'b0);
      queue_req(wtdc_pkg::REQ_PORT_B, 8'h00, 1'b1);
      queue_req(wtdc_pkg::REQ_PORT_A, 8'hff, 1'b1);
      queue_req(wtdc_pkg::REQ_PORT_A, 8'h0f, 1'b0);
      queue_req(wtdc_pkg::REQ_PORT_A, 8'hf0, 1'b0);
      queue_req(wtdc_pkg::REQ_DIVIDE_SET, 8'hff, 1'b1);
      queue_req(wtdc_pkg::REQ_PORT_B, 8'h5f, 1'b0);
      for (int i = 0; i < 6; i++) begin
         queue_req(wtdc_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
      end
      queue_req(wtdc_pkg::REQ_ENABLE_SET, 8'h00, 1'b1);
      queue_req(wtdc_pkg::REQ_TICK, 8'h00, 1'b0);
      queue_req(wtdc_pkg::REQ_TICK, 8'hff, 1'b1);
      queue_req(wtdc_pkg::REQ_ENABLE_SET, 8'hff, 1'b0);
      queue_req(wtdc_pkg::REQ_DIVIDE_SET, 8'h00, 1'b0);
      last_vol = 4'd5;

      // random: mostly setup followed by a tick run, some noise
      n = pending_reqs.size() + RANDOM_ITEMS;
      while (pending_reqs.size() < n) begin
         if ($urandom_range(0, 9) < 7) begin
            vol = ($urandom_range(0, 2) == 0) ? last_vol : 4'($urandom);
            preset = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(12, 15))
                                                 : 4'($urandom);
            last_vol = vol;
            queue_req(wtdc_pkg::REQ_PORT_B, {vol, preset}, 1'($urandom));
            if ($urandom_range(0, 1) == 0) begin
               queue_req(wtdc_pkg::REQ_DIVIDE_SET, 8'($urandom), 1'($urandom));
            end
            queue_req(wtdc_pkg::REQ_ENABLE_SET, 8'($urandom), ($urandom_range(0, 3) == 0));
            if ($urandom_range(0, 2) == 0) begin
               queue_req(wtdc_pkg::REQ_PORT_A, 8'($urandom), 1'($urandom));
            end
            repeat ($urandom_range(4, 40)) begin
               queue_req(wtdc_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               queue_req(3'($urandom_range(wtdc_pkg::REQ_TICK, REQ_CODE_MAX)),
                         8'($urandom), 1'($urandom));
            end
         end
      end
      request_total = pending_reqs.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < request_total) @(posedge clock);
      drain = 0;
      while (expected_tones.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain = drain + 1;
      end
      repeat (8) @(posedge clock);
      if (expected_tones.size() != 0) begin
         $error("%0d expected responses never arrived", expected_tones.size());
         error_count = error_count + 1;
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Hard stop well past the slowest legal run
   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/wtdc_pkg.sv
rtl/wtdc_in_reg.sv
rtl/wtdc_chain.sv
rtl/wtdc_out_reg.sv
rtl/wavetable_tone_divider_chain.sv
rtl/wtdc_checker.sv
dv/wavetable_tone_divider_chain_test.sv
